// ----- sv/gtr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_pkg: shared types and constants of the glyph text rasterizer
// Holds the configuration and result beat types, the register indexes,
// the character codes and the 5x7 glyph column table.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BG_EN = 3'd4;

  localparam logic [7:0] CODE_NL    = 8'd10;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd126;
  localparam logic [7:0] CODE_QMARK = 8'd63;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int ROM_DEPTH   = 475;
  localparam int ROM_ADDR_W  = 9;

  typedef struct packed {
    logic [5:0]  scale;
    logic        wrap_en;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        bg_en;
  } cfg_t;

  typedef struct packed {
    logic        draw;
    logic [8:0]  rect_x;
    logic [8:0]  rect_y;
    logic [5:0]  rect_w;
    logic [5:0]  rect_h;
    logic [15:0] color;
    logic [7:0]  advance;
    logic        last;
  } beat_t;

  localparam logic [6:0] GLYPH_ROM [0:ROM_DEPTH-1] = '{
    7'h00,7'h00,7'h00,7'h00,7'h00, 7'h00,7'h00,7'h5F,7'h00,7'h00,
    7'h00,7'h07,7'h00,7'h07,7'h00, 7'h14,7'h7F,7'h14,7'h7F,7'h14,
    7'h24,7'h2A,7'h7F,7'h2A,7'h12, 7'h23,7'h13,7'h08,7'h64,7'h62,
    7'h36,7'h49,7'h55,7'h22,7'h50, 7'h00,7'h05,7'h03,7'h00,7'h00,
    7'h00,7'h1C,7'h22,7'h41,7'h00, 7'h00,7'h41,7'h22,7'h1C,7'h00,
    7'h14,7'h08,7'h3E,7'h08,7'h14, 7'h08,7'h08,7'h3E,7'h08,7'h08,
    7'h00,7'h50,7'h30,7'h00,7'h00, 7'h08,7'h08,7'h08,7'h08,7'h08,
    7'h00,7'h60,7'h60,7'h00,7'h00, 7'h20,7'h10,7'h08,7'h04,7'h02,
    7'h3E,7'h51,7'h49,7'h45,7'h3E, 7'h00,7'h42,7'h7F,7'h40,7'h00,
    7'h42,7'h61,7'h51,7'h49,7'h46, 7'h21,7'h41,7'h45,7'h4B,7'h31,
    7'h18,7'h14,7'h12,7'h7F,7'h10, 7'h27,7'h45,7'h45,7'h45,7'h39,
    7'h3C,7'h4A,7'h49,7'h49,7'h30, 7'h01,7'h71,7'h09,7'h05,7'h03,
    7'h36,7'h49,7'h49,7'h49,7'h36, 7'h06,7'h49,7'h49,7'h29,7'h1E,
    7'h00,7'h36,7'h36,7'h00,7'h00, 7'h00,7'h56,7'h36,7'h00,7'h00,
    7'h08,7'h14,7'h22,7'h41,7'h00, 7'h14,7'h14,7'h14,7'h14,7'h14,
    7'h00,7'h41,7'h22,7'h14,7'h08, 7'h02,7'h01,7'h51,7'h09,7'h06,
    7'h32,7'h49,7'h79,7'h41,7'h3E, 7'h7E,7'h11,7'h11,7'h11,7'h7E,
    7'h7F,7'h49,7'h49,7'h49,7'h36, 7'h3E,7'h41,7'h41,7'h41,7'h22,
    7'h7F,7'h41,7'h41,7'h22,7'h1C, 7'h7F,7'h49,7'h49,7'h49,7'h41,
    7'h7F,7'h09,7'h09,7'h09,7'h01, 7'h3E,7'h41,7'h49,7'h49,7'h7A,
    7'h7F,7'h08,7'h08,7'h08,7'h7F, 7'h00,7'h41,7'h7F,7'h41,7'h00,
    7'h20,7'h40,7'h41,7'h3F,7'h01, 7'h7F,7'h08,7'h14,7'h22,7'h41,
    7'h7F,7'h40,7'h40,7'h40,7'h40, 7'h7F,7'h02,7'h0C,7'h02,7'h7F,
    7'h7F,7'h04,7'h08,7'h10,7'h7F, 7'h3E,7'h41,7'h41,7'h41,7'h3E,
    7'h7F,7'h09,7'h09,7'h09,7'h06, 7'h3E,7'h41,7'h51,7'h21,7'h5E,
    7'h7F,7'h09,7'h19,7'h29,7'h46, 7'h46,7'h49,7'h49,7'h49,7'h31,
    7'h01,7'h01,7'h7F,7'h01,7'h01, 7'h3F,7'h40,7'h40,7'h40,7'h3F,
    7'h1F,7'h20,7'h40,7'h20,7'h1F, 7'h3F,7'h40,7'h38,7'h40,7'h3F,
    7'h63,7'h14,7'h08,7'h14,7'h63, 7'h07,7'h08,7'h70,7'h08,7'h07,
    7'h61,7'h51,7'h49,7'h45,7'h43, 7'h00,7'h7F,7'h41,7'h41,7'h00,
    7'h02,7'h04,7'h08,7'h10,7'h20, 7'h00,7'h41,7'h41,7'h7F,7'h00,
    7'h04,7'h02,7'h01,7'h02,7'h04, 7'h40,7'h40,7'h40,7'h40,7'h40,
    7'h00,7'h01,7'h02,7'h04,7'h00, 7'h20,7'h54,7'h54,7'h54,7'h78,
    7'h7F,7'h48,7'h44,7'h44,7'h38, 7'h38,7'h44,7'h44,7'h44,7'h20,
    7'h38,7'h44,7'h44,7'h48,7'h7F, 7'h38,7'h54,7'h54,7'h54,7'h18,
    7'h08,7'h7E,7'h09,7'h01,7'h02, 7'h0C,7'h52,7'h52,7'h52,7'h3E,
    7'h7F,7'h08,7'h04,7'h04,7'h78, 7'h00,7'h44,7'h7D,7'h40,7'h00,
    7'h20,7'h40,7'h44,7'h3D,7'h00, 7'h7F,7'h10,7'h28,7'h44,7'h00,
    7'h00,7'h41,7'h7F,7'h40,7'h00, 7'h7C,7'h04,7'h18,7'h04,7'h78,
    7'h7C,7'h08,7'h04,7'h04,7'h78, 7'h38,7'h44,7'h44,7'h44,7'h38,
    7'h7C,7'h14,7'h14,7'h14,7'h08, 7'h08,7'h14,7'h14,7'h14,7'h7C,
    7'h7C,7'h08,7'h04,7'h04,7'h08, 7'h48,7'h54,7'h54,7'h54,7'h20,
    7'h04,7'h3F,7'h44,7'h40,7'h20, 7'h3C,7'h40,7'h40,7'h20,7'h7C,
    7'h1C,7'h20,7'h40,7'h20,7'h1C, 7'h3C,7'h40,7'h30,7'h40,7'h3C,
    7'h44,7'h28,7'h10,7'h28,7'h44, 7'h0C,7'h50,7'h50,7'h50,7'h3C,
    7'h44,7'h64,7'h54,7'h4C,7'h44, 7'h00,7'h08,7'h36,7'h41,7'h00,
    7'h00,7'h00,7'h7F,7'h00,7'h00, 7'h00,7'h41,7'h36,7'h08,7'h00,
    7'h10,7'h08,7'h08,7'h10,7'h08
  };

endpackage

// ----- sv/gtr_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_in_if: input channel of the glyph text rasterizer
// Carries one character or set-cursor item per beat.
// ----------------------------------------------------------------------------
interface gtr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_code;
  logic [15:0] new_x;
  logic [15:0] new_y;

  modport source (output valid, kind, char_code, new_x, new_y, input ready);
  modport sink   (input valid, kind, char_code, new_x, new_y, output ready);
endinterface

// ----- sv/gtr_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_out_if: result channel of the glyph text rasterizer
// Carries one clipped square or one terminator per beat.
// ----------------------------------------------------------------------------
interface gtr_out_if;
  logic        valid;
  logic        ready;
  logic        draw;
  logic [8:0]  rect_x;
  logic [8:0]  rect_y;
  logic [5:0]  rect_w;
  logic [5:0]  rect_h;
  logic [15:0] color;
  logic [7:0]  advance;
  logic        last;

  modport source (output valid, draw, rect_x, rect_y, rect_w, rect_h, color, advance, last,
                  input ready);
  modport sink   (input valid, draw, rect_x, rect_y, rect_w, rect_h, color, advance, last,
                  output ready);
endinterface

// ----- sv/gtr_glyph_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_glyph_rom: glyph column table with registered read
// Returns one 7-bit glyph column, bit 0 the top row, registered on rd.
// ----------------------------------------------------------------------------
module gtr_glyph_rom (
  input  logic                              clk,
  input  logic                              rd,
  input  logic [gtr_pkg::ROM_ADDR_W-1:0]    addr,
  output logic [gtr_pkg::GLYPH_ROWS-1:0]    data
);

  always_ff @(posedge clk) begin
    if (rd) begin
      data <= gtr_pkg::GLYPH_ROM[addr];
    end
  end

endmodule

// ----- sv/gtr_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_clip: shared square clip unit
// Tests a square corner against the screen and trims its size to the edges.
// ----------------------------------------------------------------------------
module gtr_clip #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320,
  parameter int PXW           = 10,
  parameter int PYW           = 10
) (
  input  logic [PXW-1:0] px,
  input  logic [PYW-1:0] py,
  input  logic [5:0]     scale,
  output logic           on_screen,
  output logic [5:0]     w,
  output logic [5:0]     h
);

  logic [PXW-1:0] dx;
  logic [PYW-1:0] dy;

  always_comb begin
    on_screen = (px < PXW'(SCREEN_WIDTH)) && (py < PYW'(SCREEN_HEIGHT));
    dx = PXW'(SCREEN_WIDTH) - px;
    dy = PYW'(SCREEN_HEIGHT) - py;
    w  = (dx < PXW'(scale)) ? 6'(dx) : scale;
    h  = (dy < PYW'(scale)) ? 6'(dy) : scale;
  end

endmodule

// ----- sv/gtr_raster.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_raster: cursor and glyph walk sequencer
// Keeps the cursor, wraps, walks glyphs one square per cycle unless stalled.
// ----------------------------------------------------------------------------
module gtr_raster #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320,
  parameter int MAX_SCALE     = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  gtr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_kind,
  input  logic [7:0]    in_char_code,
  input  logic [15:0]   in_new_x,
  input  logic [15:0]   in_new_y,
  input  logic          out_free,
  output logic          emit,
  output gtr_pkg::beat_t beat
);

  localparam int PXW = $clog2(SCREEN_WIDTH + gtr_pkg::GLYPH_COLS * MAX_SCALE + 1);
  localparam int PYW = $clog2(SCREEN_HEIGHT + gtr_pkg::GLYPH_ROWS * MAX_SCALE + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRAP  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DRAW  = 3'd3;
  localparam logic [2:0] S_TERM  = 3'd4;

  localparam logic [2:0] COL_LAST_GLYPH = 3'(gtr_pkg::GLYPH_COLS - 1);
  localparam logic [2:0] COL_SPACE      = 3'(gtr_pkg::GLYPH_COLS);
  localparam logic [2:0] ROW_LAST       = 3'(gtr_pkg::GLYPH_ROWS - 1);

  localparam logic [gtr_pkg::ROM_ADDR_W-1:0] ROM_ONE =
    {{(gtr_pkg::ROM_ADDR_W-1){1'b0}}, 1'b1};

  logic [2:0]  state, state_next;
  logic [15:0] cx, cx_next;
  logic [15:0] cy, cy_next;
  logic [gtr_pkg::ROM_ADDR_W-1:0] rom_addr, rom_addr_next;
  logic [2:0]  col, col_next;
  logic [2:0]  row, row_next;
  logic [PXW-1:0] px, px_next;
  logic [PYW-1:0] py, py_next;
  logic [7:0]  adv, adv_next;

  logic [7:0]  cw;
  logic [15:0] step_y;
  logic [7:0]  code;
  logic [6:0]  glyph_idx;
  logic [gtr_pkg::ROM_ADDR_W-1:0] base;
  logic        rom_rd;
  logic [gtr_pkg::ROM_ADDR_W-1:0] rom_rd_addr;
  logic [gtr_pkg::GLYPH_ROWS-1:0] rom_bits;
  logic        clip_on;
  logic [5:0]  clip_w, clip_h;
  logic        spacing, bit_set, want, go, col_done;

  gtr_glyph_rom u_rom (
    .clk  (clk),
    .rd   (rom_rd),
    .addr (rom_rd_addr),
    .data (rom_bits)
  );

  gtr_clip #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .PXW           (PXW),
    .PYW           (PYW)
  ) u_clip (
    .px        (px),
    .py        (py),
    .scale     (cfg.scale),
    .on_screen (clip_on),
    .w         (clip_w),
    .h         (clip_h)
  );

  always_comb begin
    cw     = ({2'b00, cfg.scale} << 2) + ({2'b00, cfg.scale} << 1);
    step_y = {7'd0, cfg.scale, 3'b000};
    code   = ((in_char_code < gtr_pkg::CODE_FIRST) || (in_char_code > gtr_pkg::CODE_LAST))
             ? gtr_pkg::CODE_QMARK : in_char_code;
    glyph_idx = 7'(code - gtr_pkg::CODE_FIRST);
    base   = {glyph_idx, 2'b00} + {2'b00, glyph_idx};

    spacing = (col == COL_SPACE);
    bit_set = !spacing && rom_bits[row];
    want    = bit_set || cfg.bg_en;
    col_done = (col == COL_SPACE) || ((col == COL_LAST_GLYPH) && !cfg.bg_en);

    in_ready = (state == S_IDLE);
    emit     = 1'b0;
    beat     = '0;
    rom_rd   = 1'b0;
    rom_rd_addr = rom_addr;
    go       = 1'b0;

    state_next    = state;
    cx_next       = cx;
    cy_next       = cy;
    rom_addr_next = rom_addr;
    col_next      = col;
    row_next      = row;
    px_next       = px;
    py_next       = py;
    adv_next      = adv;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            cx_next = in_new_x;
            cy_next = in_new_y;
          end else if (in_char_code == gtr_pkg::CODE_CR) begin
            adv_next   = '0;
            state_next = S_TERM;
          end else if (in_char_code == gtr_pkg::CODE_NL) begin
            cx_next    = '0;
            cy_next    = cy + step_y;
            adv_next   = '0;
            state_next = S_TERM;
          end else begin
            rom_addr_next = base;
            state_next    = S_WRAP;
          end
        end
      end
      S_WRAP: begin
        if (cfg.wrap_en && (({1'b0, cx} + {9'd0, cw}) > 17'(SCREEN_WIDTH))) begin
          cx_next = '0;
          cy_next = cy + step_y;
        end
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if ((cx < 16'(SCREEN_WIDTH)) && (cy < 16'(SCREEN_HEIGHT))) begin
          px_next    = PXW'(cx);
          py_next    = PYW'(cy);
          col_next   = '0;
          row_next   = '0;
          rom_rd     = 1'b1;
          state_next = S_DRAW;
        end else begin
          adv_next   = '0;
          state_next = S_TERM;
        end
      end
      S_DRAW: begin
        emit = want && clip_on;
        beat.draw   = 1'b1;
        beat.rect_x = 9'(px);
        beat.rect_y = 9'(py);
        beat.rect_w = clip_w;
        beat.rect_h = clip_h;
        beat.color  = bit_set ? cfg.fg : cfg.bg;
        go = !emit || out_free;
        if (go) begin
          if (row == ROW_LAST) begin
            row_next = '0;
            py_next  = PYW'(cy);
            if (col_done) begin
              adv_next   = cw;
              state_next = S_TERM;
            end else begin
              col_next = col + 3'd1;
              px_next  = px + PXW'(cfg.scale);
              if (col != COL_LAST_GLYPH) begin
                rom_rd        = 1'b1;
                rom_rd_addr   = rom_addr + ROM_ONE;
                rom_addr_next = rom_addr + ROM_ONE;
              end
            end
          end else begin
            row_next = row + 3'd1;
            py_next  = py + PYW'(cfg.scale);
          end
        end
      end
      S_TERM: begin
        emit = 1'b1;
        beat.advance = adv;
        beat.last    = 1'b1;
        if (out_free) begin
          cx_next    = cx + {8'd0, adv};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cx    <= '0;
      cy    <= '0;
    end else begin
      state <= state_next;
      cx    <= cx_next;
      cy    <= cy_next;
    end
  end

  always_ff @(posedge clk) begin
    rom_addr <= rom_addr_next;
    col      <= col_next;
    row      <= row_next;
    px       <= px_next;
    py       <= py_next;
    adv      <= adv_next;
  end

endmodule

// ----- sv/glyph_text_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_rasterizer: 5x7 bitmap font text renderer
// Turns characters into clipped, magnified squares and keeps a text cursor.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      beat
//  in_ch    in   valid/ready    kind, char_code, new_x, new_y
//  out_ch   out  valid/ready    draw, rect_x/y/w/h, color, advance, last
//  cfg      in   cfg_we only    cfg_index, cfg_data
//
//  A set-cursor beat is taken while idle; carriage return and newline go on
//  to the terminator. A printable character passes the accept, wrap and bounds
//  check states, then one glyph square per cycle while out_ch is free through
//  the shared clip unit (35, or 42 with background), then the terminator.
//  in_ch.ready is high only while the sequencer is idle.
//  A stalled out_ch holds the sequencer on the square it is about to emit.
//  Reset clears the cursor and loads the register defaults.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320,
  parameter int MAX_SCALE     = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  gtr_in_if.sink                             in_ch,
  gtr_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gtr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  gtr_pkg::cfg_t  cfg;
  gtr_pkg::beat_t beat;
  gtr_pkg::beat_t out_beat;
  logic           out_valid;
  logic           out_free;
  logic           emit;
  logic [5:0]     scale_wr;

  gtr_raster #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_SCALE     (MAX_SCALE)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_kind      (in_ch.kind),
    .in_char_code (in_ch.char_code),
    .in_new_x     (in_ch.new_x),
    .in_new_y     (in_ch.new_y),
    .out_free     (out_free),
    .emit         (emit),
    .beat         (beat)
  );

  always_comb begin
    scale_wr = cfg_data[5:0];
    if (scale_wr == 6'd0) begin
      scale_wr = 6'd1;
    end else if (scale_wr > 6'(MAX_SCALE)) begin
      scale_wr = 6'(MAX_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale   <= 6'd1;
      cfg.wrap_en <= 1'b1;
      cfg.fg      <= 16'hFFFF;
      cfg.bg      <= 16'h0000;
      cfg.bg_en   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtr_pkg::REG_SCALE: cfg.scale   <= scale_wr;
        gtr_pkg::REG_WRAP:  cfg.wrap_en <= cfg_data[0];
        gtr_pkg::REG_FG:    cfg.fg      <= cfg_data;
        gtr_pkg::REG_BG:    cfg.bg      <= cfg_data;
        gtr_pkg::REG_BG_EN: cfg.bg_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      out_beat <= beat;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.draw    = out_beat.draw;
  assign out_ch.rect_x  = out_beat.rect_x;
  assign out_ch.rect_y  = out_beat.rect_y;
  assign out_ch.rect_w  = out_beat.rect_w;
  assign out_ch.rect_h  = out_beat.rect_h;
  assign out_ch.color   = out_beat.color;
  assign out_ch.advance = out_beat.advance;
  assign out_ch.last    = out_beat.last;

endmodule

// ----- sv/gtr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_checker: port checks of the glyph text rasterizer
// Watches both channels and flags busy, beat format and stall slips.
// ----------------------------------------------------------------------------
module gtr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_draw,
  input logic [5:0]  out_rect_w,
  input logic [5:0]  out_rect_h,
  input logic [15:0] out_color,
  input logic [7:0]  out_advance,
  input logic        out_last
);

  a_busy_after_char: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_kind |=> !in_ready)
    else $error("input ready right after a character beat");

  a_square_format: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_draw |-> !out_last && out_advance == 8'd0 &&
                              out_rect_w != 6'd0 && out_rect_h != 6'd0)
    else $error("malformed square beat");

  a_term_format: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_draw |-> out_last && out_rect_w == 6'd0 &&
                               out_rect_h == 6'd0 && out_color == 16'd0)
    else $error("malformed terminator beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_draw) &&
                                $stable(out_color) && $stable(out_advance))
    else $error("output beat dropped or changed while stalled");

endmodule

bind glyph_text_rasterizer gtr_checker u_gtr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_kind     (in_ch.kind),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_draw    (out_ch.draw),
  .out_rect_w  (out_ch.rect_w),
  .out_rect_h  (out_ch.rect_h),
  .out_color   (out_ch.color),
  .out_advance (out_ch.advance),
  .out_last    (out_ch.last)
);

// ----- tb/gtr_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_tb_pkg: testbench codes for the glyph text rasterizer
// Names the two input beat kinds and a register index the block does not
// decode.
// ----------------------------------------------------------------------------
package gtr_tb_pkg;

  typedef enum logic {
    KIND_CHAR   = 1'b0,
    KIND_CURSOR = 1'b1
  } item_kind_e;

  localparam logic [gtr_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

endpackage

// ----- tb/gtr_render_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_render_checker: scoreboard for the glyph text rasterizer
// Snoops the register writes and the input channel, renders each accepted
// character into the squares and terminator it must produce, and compares
// every accepted result beat field by field against the oldest pending one.
// ----------------------------------------------------------------------------
module gtr_render_checker #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320,
  parameter int MAX_SCALE     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  gtr_in_if                              in_ch,
  gtr_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fails,
  output int                             pending
);
  import gtr_pkg::*;
  import gtr_tb_pkg::*;

  cfg_t        regs;
  logic [15:0] cur_x;
  logic [15:0] cur_y;
  beat_t       beats_due[$];
  beat_t       want;
  int          mismatches = 0;
  logic [5:0]  new_scale;

  function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] got);
    if (got !== exp_val) begin
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got);
    end
  endfunction

  function automatic void queue_square(int unsigned px, int unsigned py, logic [15:0] col);
    int unsigned s;
    beat_t sq;
    s = regs.scale;
    if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
      return;
    sq = '0;
    sq.draw   = 1'b1;
    sq.rect_x = 9'(px);
    sq.rect_y = 9'(py);
    sq.rect_w = 6'((SCREEN_WIDTH - px < s) ? SCREEN_WIDTH - px : s);
    sq.rect_h = 6'((SCREEN_HEIGHT - py < s) ? SCREEN_HEIGHT - py : s);
    sq.color  = col;
    beats_due.push_back(sq);
  endfunction

  function automatic void render_item(logic kind, logic [7:0] code_in,
                                      logic [15:0] nx, logic [15:0] ny);
    int unsigned s, cw, base, col, row;
    logic [7:0] code;
    logic [6:0] bits;
    logic [7:0] adv;
    beat_t term;
    s = regs.scale;
    cw = 6 * s;
    adv = '0;
    code = code_in;
    if (kind == KIND_CURSOR) begin
      cur_x = nx;
      cur_y = ny;
      return;
    end
    if (code == CODE_CR) begin
      adv = '0;
    end else if (code == CODE_NL) begin
      cur_x = '0;
      cur_y = cur_y + 16'(8 * s);
    end else begin
      if (code < CODE_FIRST || code > CODE_LAST)
        code = CODE_QMARK;
      base = (code - CODE_FIRST) * GLYPH_COLS;
      if (regs.wrap_en && (cur_x + cw > SCREEN_WIDTH)) begin
        cur_x = '0;
        cur_y = cur_y + 16'(8 * s);
      end
      if (cur_x < SCREEN_WIDTH && cur_y < SCREEN_HEIGHT) begin
        for (col = 0; col < GLYPH_COLS; col++) begin
          bits = GLYPH_ROM[base + col];
          for (row = 0; row < GLYPH_ROWS; row++) begin
            if (bits[row])
              queue_square(cur_x + col * s, cur_y + row * s, regs.fg);
            else if (regs.bg_en)
              queue_square(cur_x + col * s, cur_y + row * s, regs.bg);
          end
        end
        if (regs.bg_en) begin
          for (row = 0; row < GLYPH_ROWS; row++)
            queue_square(cur_x + GLYPH_COLS * s, cur_y + row * s, regs.bg);
        end
        cur_x = cur_x + 16'(cw);
        adv = 8'(cw);
      end
    end
    term = '0;
    term.advance = adv;
    term.last = 1'b1;
    beats_due.push_back(term);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.scale   = 6'd1;
      regs.wrap_en = 1'b1;
      regs.fg      = 16'hFFFF;
      regs.bg      = 16'h0000;
      regs.bg_en   = 1'b0;
      cur_x = '0;
      cur_y = '0;
      beats_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE: begin
            new_scale = cfg_data[5:0];
            if (new_scale == 6'd0)
              new_scale = 6'd1;
            else if (new_scale > MAX_SCALE)
              new_scale = 6'(MAX_SCALE);
            regs.scale = new_scale;
          end
          REG_WRAP:  regs.wrap_en = cfg_data[0];
          REG_FG:    regs.fg = cfg_data;
          REG_BG:    regs.bg = cfg_data;
          REG_BG_EN: regs.bg_en = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        render_item(in_ch.kind, in_ch.char_code, in_ch.new_x, in_ch.new_y);
      if (out_ch.valid && out_ch.ready) begin
        if (beats_due.size() == 0) begin
          mismatches++;
          $error("result beat with nothing pending");
        end else begin
          want = beats_due.pop_front();
          check_field("draw", 16'(want.draw), 16'(out_ch.draw));
          check_field("rect_x", 16'(want.rect_x), 16'(out_ch.rect_x));
          check_field("rect_y", 16'(want.rect_y), 16'(out_ch.rect_y));
          check_field("rect_w", 16'(want.rect_w), 16'(out_ch.rect_w));
          check_field("rect_h", 16'(want.rect_h), 16'(out_ch.rect_h));
          check_field("color", want.color, out_ch.color);
          check_field("advance", 16'(want.advance), 16'(out_ch.advance));
          check_field("last", 16'(want.last), 16'(out_ch.last));
        end
      end
    end
    pending <= beats_due.size();
    fails   <= mismatches;
  end

endmodule

// ----- tb/glyph_text_rasterizer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_rasterizer_test: top level testbench of the glyph text rasterizer
// Drives directed edge cases (clipping, wrap, cursor overflow, control and
// unprintable codes, scale saturation) and then random text under random
// register settings, with bursty stalls on both channels, a long output
// hold-off and a drained pause. The checker scores every result beat.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer_test;
  import gtr_pkg::*;
  import gtr_tb_pkg::*;

  localparam int SCREEN_W  = 480;
  localparam int SCREEN_H  = 320;
  localparam int SCALE_MAX = 32;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    idle_on = 1'b1;
  bit                    hold_req = 1'b0;
  int                    fails;
  int                    pending;

  gtr_in_if  in_ch ();
  gtr_out_if out_ch ();

  glyph_text_rasterizer #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H),
    .MAX_SCALE    (SCALE_MAX)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  gtr_render_checker #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H),
    .MAX_SCALE    (SCALE_MAX)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #15_000_000;
    $display("[glyph_text_rasterizer] ERROR");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_beat(input logic kind, input logic [7:0] code,
                           input logic [15:0] x, input logic [15:0] y);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.kind      = kind;
    in_ch.char_code = code;
    in_ch.new_x     = x;
    in_ch.new_y     = y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] code);
    send_beat(KIND_CHAR, code, 16'($urandom), 16'($urandom));
  endtask

  task automatic set_cursor(input logic [15:0] x, input logic [15:0] y);
    send_beat(KIND_CURSOR, 8'($urandom), x, y);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_all(input logic [15:0] sc, input logic [15:0] wr,
                           input logic [15:0] fg, input logic [15:0] bg,
                           input logic [15:0] be);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{REG_SCALE, REG_WRAP, REG_FG, REG_BG, REG_BG_EN, REG_NONE};
    val = '{sc, wr, fg, bg, be, 16'($urandom)};
    drain();
    cfg_we = 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index = idx[i];
      cfg_data  = val[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  function automatic logic [15:0] rand_coord(input int span);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'(span - 8 + $urandom_range(0, 15));
      default: return 16'($urandom_range(0, span - 1));
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      set_cursor(rand_coord(SCREEN_W), rand_coord(SCREEN_H));
    else if (pick < 16)
      send_char(CODE_NL);
    else if (pick < 19)
      send_char(CODE_CR);
    else if (pick < 27)
      send_char(8'($urandom_range(0, 255)));
    else
      send_char(8'($urandom_range(CODE_FIRST, CODE_LAST)));
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_CHAR;
    in_ch.char_code = '0;
    in_ch.new_x     = '0;
    in_ch.new_y     = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset settings: foreground only, wrap on
    send_char(8'h41);
    send_char(CODE_CR);
    send_char(CODE_NL);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CODE_FIRST);
    send_char(CODE_LAST);
    set_cursor(16'd474, 16'd0);
    send_char(8'h57);
    send_char(8'h4D);
    set_cursor(16'd5, 16'hFFFA);
    send_char(CODE_NL);
    send_char(8'h67);

    // largest scale, no wrap, background on
    write_all(16'h0020, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
    set_cursor(16'd0, 16'd0);
    send_char(8'h23);
    set_cursor(16'd470, 16'd300);
    send_char(8'h42);
    set_cursor(16'hFFFF, 16'hFFFF);
    send_char(8'h78);
    set_cursor(16'd479, 16'd319);
    send_char(8'h40);

    // zero scale becomes one, wrap from the far corner
    write_all(16'hFFC0, 16'hFFFF, 16'($urandom), 16'($urandom), 16'hFFFF);
    set_cursor(16'hFFFF, 16'hFFFF);
    send_char(8'h24);

    // oversized scale saturates
    write_all(16'h003F, 16'h0001, 16'($urandom), 16'($urandom), 16'h0000);
    set_cursor(16'd300, 16'd0);
    send_char(8'h51);
    send_char(CODE_NL);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7)
        idle_on = 1'b0;
      write_all(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      if (phase == 3)
        hold_req = 1'b1;
      for (int n = 0; n < 45; n++) begin
        if (phase == 5 && n == 20)
          drain();
        random_item();
      end
    end

    drain();
    repeat (60) @(negedge clk);
    if (fails == 0)
      $display("[glyph_text_rasterizer] OK");
    else
      $display("[glyph_text_rasterizer] ERROR");
    $finish;
  end

endmodule
